/* hw/rtl/ucf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared constants and types for the undirected cycle finder.
// ----------------------------------------------------------------------------
package ucf_pkg;
  localparam int MaxVertices = 64;
  localparam int VidW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int RowW        = 64;
  localparam int NumLanes    = 8;
  localparam int LaneW       = MaxVertices / NumLanes;
  localparam int StkW        = 2 * VidW + CntW;
  localparam int ColW        = 2 + VidW;

  typedef logic [VidW-1:0] vid_t;
  typedef logic [CntW-1:0] cnt_t;

  // Per-lane scan result handed to the merge stage
  typedef struct packed {
    logic hit;
    vid_t idx;
  } lane_hit_t;

  // Stack entry: vertex, next scan position, parent vertex
  typedef struct packed {
    vid_t v;
    cnt_t p;
    vid_t par;
  } stk_ent_t;

  // Per-vertex entry: color and stack position while gray
  typedef struct packed {
    logic [1:0] col;
    vid_t       spos;
  } col_ent_t;

  // Vertex color codes
  localparam logic [1:0] ColWhite = 2'd0;
  localparam logic [1:0] ColGray  = 2'd1;
  localparam logic [1:0] ColBlack = 2'd2;
endpackage

/* hw/rtl/ucf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ucf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/ucf_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_lane
// One scan lane: finds the lowest set bit of its slice.
// ----------------------------------------------------------------------------
module ucf_lane (
  input  logic [ucf_pkg::LaneW-1:0] bits,
  input  logic [ucf_pkg::VidW-1:0]  base,
  output ucf_pkg::lane_hit_t        res
);
  import ucf_pkg::*;

  // Priority pick, lowest index wins
  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = LaneW - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.hit = 1'b1;
        res.idx = base + VidW'(i);
      end
    end
  end
endmodule

/* hw/rtl/ucf_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_merge
// Merge stage: first lane with a hit gives the next neighbor.
// ----------------------------------------------------------------------------
module ucf_merge (
  input  ucf_pkg::lane_hit_t lanes [ucf_pkg::NumLanes],
  output ucf_pkg::lane_hit_t res
);
  import ucf_pkg::*;

  always_comb begin
    res = '0;
    for (int l = NumLanes - 1; l >= 0; l--) begin
      if (lanes[l].hit) begin
        res = lanes[l];
      end
    end
  end
endmodule

/* hw/rtl/undirected_cycle_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// undirected_cycle_finder
// DFS cycle finder over a loaded adjacency matrix, lane-parallel neighbor scan.
// ----------------------------------------------------------------------------
// Rows load one per request. The request with in_last_row set starts a
// search; busy stays high until the cycle in which the last result is
// shown, and falls in that cycle. A search first clears the colors of the
// n vertices, one per cycle. Each root check reads the root's color and
// then tests it, and a final step reports not-found when the roots run
// out. Each neighbor examined takes a registered row read, a lane scan and
// a registered color read, and each vertex retired takes a read, an empty
// scan and a stack restore. Every set row bit is examined at most once.
// Then each cycle vertex, or the single not-found result, is registered
// and shown under out_valid.
// The receiver cannot stall: every result is shown once and must be taken.
module undirected_cycle_finder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [63:0]              in_row_bits,
  input  logic                     in_last_row,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [6:0]               cfg_vertex_count,
  output logic                     out_valid,
  output logic                     out_cycle_found,
  output logic [6:0]               out_cycle_length,
  output logic [6:0]               out_cycle_vertex,
  output logic                     out_last_result
);
  import ucf_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_ROOT, S_RCHK, S_READ, S_SCAN, S_CCHK, S_POP, S_EMIT, S_NONE
  } state_t;

  state_t          state_r;
  logic [6:0]      vcount_r;
  cnt_t            rowcnt_r;
  cnt_t            n_r;
  logic [RowW-1:0] mask_r;
  cnt_t            clr_r;
  cnt_t            root_r;
  cnt_t            depth_r;
  vid_t            top_v_r;
  cnt_t            top_p_r;
  vid_t            top_par_r;
  vid_t            nb_r;
  cnt_t            emit_r;
  cnt_t            len_r;

  // Adjacency store
  logic            ram_we;
  vid_t            ram_waddr, ram_raddr;
  logic [RowW-1:0] ram_rdata;

  assign ram_we    = (state_r == S_LOAD) && start && (rowcnt_r < cnt_t'(MaxVertices));
  assign ram_waddr = rowcnt_r[VidW-1:0];
  assign ram_raddr = top_v_r;

  ucf_ram #(.Width(RowW), .Depth(MaxVertices)) u_adj (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(in_row_bits),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Lanes scan the row from the stored scan position upward
  logic [RowW-1:0] scan_bits;
  lane_hit_t       lane_res [NumLanes];
  lane_hit_t       nb;

  always_comb begin
    scan_bits = ram_rdata & mask_r;
    for (int b = 0; b < RowW; b++) begin
      if (CntW'(b) < top_p_r) scan_bits[b] = 1'b0;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ucf_lane u_lane (
      .bits(scan_bits[l*LaneW +: LaneW]),
      .base(VidW'(l*LaneW)),
      .res(lane_res[l])
    );
  end

  ucf_merge u_merge (.lanes(lane_res), .res(nb));

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = (state_r == S_LOAD);

  // Vertex colors and stack positions
  logic     col_we;
  vid_t     col_waddr, col_raddr;
  col_ent_t col_wdata, col_rdata;

  always_comb begin
    col_we         = 1'b0;
    col_waddr      = top_v_r;
    col_wdata.col  = ColWhite;
    col_wdata.spos = '0;
    col_raddr      = nb.idx;
    case (state_r)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = clr_r[VidW-1:0];
      end
      S_ROOT: begin
        col_raddr = root_r[VidW-1:0];
      end
      S_RCHK: begin
        if (col_rdata.col == ColWhite) begin
          col_we        = 1'b1;
          col_waddr     = root_r[VidW-1:0];
          col_wdata.col = ColGray;
        end
      end
      S_SCAN: begin
        if (!nb.hit) begin
          col_we        = 1'b1;
          col_waddr     = top_v_r;
          col_wdata.col = ColBlack;
        end
      end
      S_CCHK: begin
        if (col_rdata.col == ColWhite) begin
          col_we         = 1'b1;
          col_waddr      = nb_r;
          col_wdata.col  = ColGray;
          col_wdata.spos = depth_r[VidW-1:0];
        end
      end
      default: ;
    endcase
  end

  ucf_ram #(.Width(ColW), .Depth(MaxVertices)) u_col (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  // Stack entries below the top; the top lives in registers
  logic     stk_we;
  vid_t     stk_waddr, stk_raddr;
  stk_ent_t stk_wdata, stk_rdata;

  assign stk_we        = (state_r == S_CCHK) && (col_rdata.col == ColWhite) &&
                         (depth_r < cnt_t'(MaxVertices));
  assign stk_waddr     = VidW'(depth_r - cnt_t'(1));
  assign stk_wdata.v   = top_v_r;
  assign stk_wdata.p   = top_p_r;
  assign stk_wdata.par = top_par_r;
  assign stk_raddr     = (state_r == S_EMIT) ? VidW'(depth_r - cnt_t'(2) - emit_r)
                                             : VidW'(depth_r - cnt_t'(2));

  ucf_ram #(.Width(StkW), .Depth(MaxVertices)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Parent check for the current top
  logic is_parent;
  assign is_parent = (depth_r >= cnt_t'(2)) && (top_par_r == nb_r);

  // Control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      vcount_r  <= 7'd1;
      rowcnt_r  <= '0;
      depth_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (cfg_valid) vcount_r <= cfg_vertex_count;
          if (start) begin
            if (in_last_row) begin
              rowcnt_r <= '0;
              n_r <= (vcount_r > 7'(MaxVertices)) ? cnt_t'(MaxVertices)
                                                  : cnt_t'(vcount_r);
              for (int b = 0; b < RowW; b++)
                mask_r[b] <= (b < MaxVertices) &&
                  (7'(b) < vcount_r);
              clr_r   <= '0;
              root_r  <= '0;
              depth_r <= '0;
              state_r <= S_CLEAR;
            end else if (rowcnt_r < cnt_t'(MaxVertices)) begin
              rowcnt_r <= rowcnt_r + cnt_t'(1);
            end
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + cnt_t'(1);
          if (clr_r + cnt_t'(1) >= n_r) state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_r >= n_r) begin
            state_r <= S_NONE;
          end else begin
            state_r <= S_RCHK;
          end
        end
        S_RCHK: begin
          root_r <= root_r + cnt_t'(1);
          if (col_rdata.col == ColWhite) begin
            top_v_r   <= root_r[VidW-1:0];
            top_p_r   <= '0;
            top_par_r <= '0;
            depth_r   <= cnt_t'(1);
            state_r   <= S_READ;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_READ: state_r <= S_SCAN;
        S_SCAN: begin
          if (!nb.hit) begin
            depth_r <= depth_r - cnt_t'(1);
            state_r <= (depth_r == cnt_t'(1)) ? S_ROOT : S_POP;
          end else begin
            top_p_r <= cnt_t'(nb.idx) + cnt_t'(1);
            nb_r    <= nb.idx;
            state_r <= S_CCHK;
          end
        end
        S_CCHK: begin
          if (col_rdata.col == ColWhite) begin
            if (depth_r < cnt_t'(MaxVertices)) begin
              top_v_r   <= nb_r;
              top_p_r   <= '0;
              top_par_r <= top_v_r;
              depth_r   <= depth_r + cnt_t'(1);
            end
            state_r <= S_READ;
          end else if (col_rdata.col == ColGray && !is_parent) begin
            len_r   <= depth_r - cnt_t'(col_rdata.spos);
            emit_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_READ;
          end
        end
        S_POP: begin
          top_v_r   <= stk_rdata.v;
          top_p_r   <= stk_rdata.p;
          top_par_r <= stk_rdata.par;
          state_r   <= S_READ;
        end
        S_EMIT: begin
          out_valid        <= 1'b1;
          out_cycle_found  <= 1'b1;
          out_cycle_length <= 7'(len_r);
          out_cycle_vertex <= (emit_r == '0) ? 7'(top_v_r) + 7'd1
                                             : 7'(stk_rdata.v) + 7'd1;
          out_last_result  <= (emit_r + cnt_t'(1) == len_r);
          emit_r           <= emit_r + cnt_t'(1);
          if (emit_r + cnt_t'(1) == len_r) state_r <= S_LOAD;
        end
        S_NONE: begin
          out_valid        <= 1'b1;
          out_cycle_found  <= 1'b0;
          out_cycle_length <= '0;
          out_cycle_vertex <= '0;
          out_last_result  <= 1'b1;
          state_r          <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

/* hw/rtl/ucf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucf_checker
// Port-level checks for the undirected cycle finder.
// ----------------------------------------------------------------------------
module ucf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_cycle_found,
  input logic [6:0] out_cycle_length,
  input logic [6:0] out_cycle_vertex,
  input logic       out_last_result
);
  // A result other than the last shows only while a search is in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> busy) else $error("result outside search");

  // Not-found result is single and empty
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cycle_found |-> out_last_result && out_cycle_length == 7'd0
      && out_cycle_vertex == 7'd0) else $error("bad not-found result");

  // Found vertices are numbered from one
  a_vtx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_found |-> out_cycle_vertex != 7'd0
      && out_cycle_length != 7'd0) else $error("bad cycle vertex");

  // Config is accepted only when idle
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("config ready while busy");
endmodule

bind undirected_cycle_finder ucf_checker u_ucf_checker (
  .clk, .rst_n, .busy, .cfg_ready, .out_valid, .out_cycle_found,
  .out_cycle_length, .out_cycle_vertex, .out_last_result
);
